// ===== rtl/core/lfows_pkg.sv =====
`timescale 1ns / 1ps

package lfows_pkg;

  // field widths
  localparam int IDX_W     = 6;
  localparam int IDX_DEPTH = 1 << IDX_W;
  localparam int LVL_W     = 7;
  localparam int SHAPE_W   = 3;
  localparam int DEC_W     = 16;
  localparam int FRAC_W    = 32;
  localparam int PROD_W    = LVL_W + IDX_W;
  localparam int COS_W     = 16;

  // reciprocal division of products below 2^PROD_W by a constant up to 255
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  // register file
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_SHAPE     = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [1:0] REG_DECAY     = 2'd2;

  localparam logic [SHAPE_W-1:0] SHAPE_RST     = 3'd0;
  localparam logic [LVL_W-1:0]   AMPLITUDE_RST = 7'd127;
  localparam logic [DEC_W-1:0]   DECAY_RST     = 16'd63065;

  // waveform shape codes
  localparam logic [SHAPE_W-1:0] SHAPE_OFF      = 3'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_EXP      = 3'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_INV_EXP  = 3'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_RAMP_UP  = 3'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_RAMP_DN  = 3'd4;
  localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 3'd5;
  localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 3'd6;

  typedef struct packed {
    logic [SHAPE_W-1:0] shape;
    logic [LVL_W-1:0]   amplitude;
    logic [DEC_W-1:0]   decay_factor;
  } cfg_t;

  // partial results of the non-exponential shapes, carried along the chain
  typedef struct packed {
    logic [PROD_W-1:0] x_up;
    logic [PROD_W-1:0] x_tri;
    logic              tri_hi;
    logic [LVL_W-1:0]  sine;
  } side_t;

  // what one exponent cell hands to the next
  typedef struct packed {
    logic [IDX_W-1:0]  n_rest;
    logic              p_one;
    logic [FRAC_W-1:0] p_frac;
    logic [FRAC_W-1:0] base;
    side_t             side;
  } cell_t;

  typedef logic [COS_W-1:0] rom_t [IDX_DEPTH];

endpackage

// ===== rtl/core/lfows_regs.sv =====
`timescale 1ns / 1ps

module lfows_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfows_pkg::ADDR_W-1:0] paddr,
  input  logic [lfows_pkg::DATA_W-1:0] pwdata,
  output logic [lfows_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output lfows_pkg::cfg_t              cfg
);

  lfows_pkg::cfg_t cfg_r, cfg_nxt;
  logic            wr_en;
  logic [1:0]      reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        lfows_pkg::REG_SHAPE:     cfg_nxt.shape        = pwdata[lfows_pkg::SHAPE_W-1:0];
        lfows_pkg::REG_AMPLITUDE: cfg_nxt.amplitude    = pwdata[lfows_pkg::LVL_W-1:0];
        lfows_pkg::REG_DECAY:     cfg_nxt.decay_factor = pwdata[lfows_pkg::DEC_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shape        <= lfows_pkg::SHAPE_RST;
      cfg_r.amplitude    <= lfows_pkg::AMPLITUDE_RST;
      cfg_r.decay_factor <= lfows_pkg::DECAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      lfows_pkg::REG_SHAPE:
        prdata = {{(lfows_pkg::DATA_W-lfows_pkg::SHAPE_W){1'b0}}, cfg_r.shape};
      lfows_pkg::REG_AMPLITUDE:
        prdata = {{(lfows_pkg::DATA_W-lfows_pkg::LVL_W){1'b0}}, cfg_r.amplitude};
      lfows_pkg::REG_DECAY:
        prdata = {{(lfows_pkg::DATA_W-lfows_pkg::DEC_W){1'b0}}, cfg_r.decay_factor};
      default:
        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/lfows_exp_cell.sv =====
`timescale 1ns / 1ps

// one bit of square-and-multiply: p *= base if the bit is set, base = base^2
module lfows_exp_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  lfows_pkg::cell_t cell_i,
  output logic             vld_o,
  output lfows_pkg::cell_t cell_o
);

  logic                      vld_r;
  lfows_pkg::cell_t          cell_r, cell_nxt;
  logic [2*lfows_pkg::FRAC_W-1:0] pb_prod;
  logic [2*lfows_pkg::FRAC_W-1:0] bb_prod;

  assign pb_prod = cell_i.p_frac * cell_i.base;
  assign bb_prod = cell_i.base * cell_i.base;

  // update partial power and square the base
  always_comb begin
    cell_nxt        = cell_i;
    cell_nxt.n_rest = cell_i.n_rest >> 1;
    if (cell_i.n_rest[0]) begin
      cell_nxt.p_one = 1'b0;
      if (cell_i.p_one) begin
        cell_nxt.p_frac = cell_i.base;
      end else begin
        cell_nxt.p_frac = pb_prod[2*lfows_pkg::FRAC_W-1:lfows_pkg::FRAC_W];
      end
    end
    cell_nxt.base = bb_prod[2*lfows_pkg::FRAC_W-1:lfows_pkg::FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign vld_o  = vld_r;
  assign cell_o = cell_r;

endmodule

// ===== rtl/core/lfo_waveform_sample_core.sv =====
`timescale 1ns / 1ps

// LFO waveform sample core
// Input channel: a transaction is taken on a clock edge with start high and
// busy low; in_sample_index is the position within the period (indexes at or
// past LENGTH read as LENGTH-1). One index may be taken every cycle.
// Result channel: out_level is valid for exactly one cycle with out_valid
// high, after the entry stage, the exponent cells and the output register,
// in the order taken. The receiver has no backpressure: results must be
// taken as they appear. The pipeline is an entry stage, a chain of six
// exponent cells (one per index bit, each with its own multipliers) and an
// output stage. Throughput: one transaction per cycle while busy is low.
// Configuration: APB registers at byte address 0 shape, 4 amplitude,
// 8 decay_factor; write only while no transaction is in flight.
// Reset (synchronous, rst_n low): registers return to shape off, amplitude
// 127, decay 63065; in-flight transactions are dropped and busy stays high
// until the cycle after reset is released.
module lfo_waveform_sample_core #(
  parameter int LENGTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [lfows_pkg::IDX_W-1:0]     in_sample_index,
  output logic                            out_valid,
  output logic [lfows_pkg::LVL_W-1:0]     out_level,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lfows_pkg::ADDR_W-1:0]    paddr,
  input  logic [lfows_pkg::DATA_W-1:0]    pwdata,
  output logic [lfows_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);

  localparam int  IDX_W      = lfows_pkg::IDX_W;
  localparam int  LVL_W      = lfows_pkg::LVL_W;
  localparam int  PROD_W     = lfows_pkg::PROD_W;
  localparam int  RSH        = lfows_pkg::RECIP_SHIFT;
  localparam int  HALF       = LENGTH / 2;
  localparam logic [7:0] LEN_M1 = 8'(LENGTH - 1);
  localparam logic [7:0] HALF_8 = 8'(HALF);
  localparam logic [lfows_pkg::RECIP_W-1:0] M_LEN =
    lfows_pkg::RECIP_W'(((1 << RSH) + LENGTH - 1) / LENGTH);
  localparam logic [lfows_pkg::RECIP_W-1:0] M_HALF =
    lfows_pkg::RECIP_W'(((1 << RSH) + HALF - 1) / HALF);
  localparam longint Q30_ONE     = longint'(1) << 30;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint LENGTH_L    = longint'(LENGTH);

  // cosine table, evaluated at elaboration
  function automatic longint q30_mul(longint a, longint b);
    return (a * b) / Q30_ONE;
  endfunction

  function automatic logic [lfows_pkg::COS_W-1:0] raised_cos(int idx);
    longint quad;
    longint rem;
    longint x;
    longint x2;
    longint t;
    longint val;
    quad = longint'(4 * idx) / LENGTH_L;
    rem  = longint'(4 * idx) - quad * LENGTH_L;
    x    = (HALF_PI_Q30 * rem) / LENGTH_L;
    x2   = q30_mul(x, x);
    t    = Q30_ONE;
    if (quad[0]) begin
      t   = Q30_ONE - q30_mul(x2, t) / 110;
      t   = Q30_ONE - q30_mul(x2, t) / 72;
      t   = Q30_ONE - q30_mul(x2, t) / 42;
      t   = Q30_ONE - q30_mul(x2, t) / 20;
      t   = Q30_ONE - q30_mul(x2, t) / 6;
      val = q30_mul(x, t);
    end else begin
      t   = Q30_ONE - q30_mul(x2, t) / 90;
      t   = Q30_ONE - q30_mul(x2, t) / 56;
      t   = Q30_ONE - q30_mul(x2, t) / 30;
      t   = Q30_ONE - q30_mul(x2, t) / 12;
      t   = Q30_ONE - q30_mul(x2, t) / 2;
      val = t;
    end
    if (val < 0) val = 0;
    if (val > Q30_ONE) val = Q30_ONE;
    val = (val + 16384) / 32768;
    if (val > 32767) val = 32767;
    if (quad == 1 || quad == 2) val = -val;
    return lfows_pkg::COS_W'(32768 - val);
  endfunction

  function automatic lfows_pkg::rom_t build_rom();
    lfows_pkg::rom_t rom;
    for (int i = 0; i < lfows_pkg::IDX_DEPTH; i++) begin
      rom[i] = (i < LENGTH) ? raised_cos(i) : '0;
    end
    return rom;
  endfunction

  localparam lfows_pkg::rom_t RCOS = build_rom();

  lfows_pkg::cfg_t cfg;

  logic                     busy_r;
  logic                     accept;
  logic [IDX_W-1:0]         n_sat;
  logic [7:0]               idx_ext;
  logic                     tri_hi;
  logic [IDX_W-1:0]         tri_n;
  logic [lfows_pkg::COS_W+LVL_W-1:0] sine_prod;
  lfows_pkg::cell_t         entry_nxt;

  logic                     vld_r [IDX_W+1];
  lfows_pkg::cell_t         cell_r [IDX_W+1];

  logic [lfows_pkg::FRAC_W+LVL_W-1:0]   exp_prod;
  logic [PROD_W+lfows_pkg::RECIP_W-1:0] up_prod;
  logic [PROD_W+lfows_pkg::RECIP_W-1:0] tri_prod;
  logic [LVL_W-1:0]         exp_lvl;
  logic [LVL_W-1:0]         up_q;
  logic [LVL_W-1:0]         tri_q;
  logic [LVL_W-1:0]         level_nxt;
  logic                     out_valid_r;
  logic [LVL_W-1:0]         out_level_r;

  lfows_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // busy only while in reset and the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  // index saturation and triangle fold
  assign idx_ext = {{(8-IDX_W){1'b0}}, in_sample_index};
  assign n_sat   = (idx_ext > LEN_M1) ? LEN_M1[IDX_W-1:0] : in_sample_index;
  assign tri_hi  = {{(8-IDX_W){1'b0}}, n_sat} > HALF_8;
  always_comb begin
    if (tri_hi) begin
      tri_n = IDX_W'({{(8-IDX_W){1'b0}}, n_sat} - HALF_8);
    end else begin
      tri_n = n_sat;
    end
  end

  assign sine_prod = cfg.amplitude * RCOS[n_sat];

  // entry stage: seed the exponent chain and start the other shapes
  always_comb begin
    entry_nxt             = '0;
    entry_nxt.n_rest      = n_sat;
    entry_nxt.p_one       = 1'b1;
    entry_nxt.p_frac      = '0;
    entry_nxt.base        = {cfg.decay_factor, {(lfows_pkg::FRAC_W-lfows_pkg::DEC_W){1'b0}}};
    entry_nxt.side.x_up   = cfg.amplitude * n_sat;
    entry_nxt.side.x_tri  = cfg.amplitude * tri_n;
    entry_nxt.side.tri_hi = tri_hi;
    entry_nxt.side.sine   = sine_prod[lfows_pkg::COS_W +: LVL_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    cell_r[0] <= entry_nxt;
  end

  // chain of exponent cells, one per index bit
  for (genvar k = 0; k < IDX_W; k++) begin : g_cell
    lfows_exp_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_r[k]),
      .cell_i (cell_r[k]),
      .vld_o  (vld_r[k+1]),
      .cell_o (cell_r[k+1])
    );
  end

  // final scaling and reciprocal divides
  assign exp_prod = cfg.amplitude * cell_r[IDX_W].p_frac;
  assign up_prod  = cell_r[IDX_W].side.x_up * M_LEN;
  assign tri_prod = cell_r[IDX_W].side.x_tri * M_HALF;
  assign exp_lvl  = cell_r[IDX_W].p_one ? cfg.amplitude
                                        : exp_prod[lfows_pkg::FRAC_W +: LVL_W];
  assign up_q     = up_prod[RSH +: LVL_W];
  assign tri_q    = tri_prod[RSH +: LVL_W];

  // shape select
  always_comb begin
    case (cfg.shape)
      lfows_pkg::SHAPE_OFF:      level_nxt = '0;
      lfows_pkg::SHAPE_EXP:      level_nxt = exp_lvl;
      lfows_pkg::SHAPE_INV_EXP:  level_nxt = cfg.amplitude - exp_lvl;
      lfows_pkg::SHAPE_RAMP_UP:  level_nxt = up_q;
      lfows_pkg::SHAPE_RAMP_DN:  level_nxt = cfg.amplitude - up_q;
      lfows_pkg::SHAPE_TRIANGLE: level_nxt = cell_r[IDX_W].side.tri_hi ?
                                             cfg.amplitude - tri_q : tri_q;
      lfows_pkg::SHAPE_SINE:     level_nxt = cell_r[IDX_W].side.sine;
      default:                   level_nxt = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[IDX_W];
    end
  end

  always_ff @(posedge clk) begin
    out_level_r <= level_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

endmodule

// ===== rtl/core/lfows_checker.sv =====
`timescale 1ns / 1ps

module lfows_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic psel,
  input logic penable,
  input logic pready
);

  localparam int LAT = 8;

  // every accepted transaction gives one result after the pipeline depth
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after accepted transaction");

  // no result without an accepted transaction
  a_result_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching transaction");

  // busy clears once reset has been released for a cycle
  a_busy_after_reset: assert property (@(posedge clk)
    ($past(rst_n) && rst_n) |-> !busy)
    else $error("busy high outside reset");

  // config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable) |-> pready)
    else $error("pready low during access");

endmodule

bind lfo_waveform_sample_core lfows_checker u_lfows_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .psel      (psel),
  .penable   (penable),
  .pready    (pready)
);
